// ===== design/pidpi_pkg.sv =====
// Shared constants and types for the fixed-point PID controller.
// No dependencies; every other design file imports this package.
`default_nettype none

package pidpi_pkg;

  localparam int DATA_WIDTH_DEF     = 16;
  localparam int INTEGRAL_WIDTH_DEF = 24;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int FUNC_W    = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_POS    = 2'd0,
    FUNC_DIRECT = 2'd1,
    FUNC_INCR   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP   = 3'd0,
    CFG_KI   = 3'd1,
    CFG_KD   = 3'd2,
    CFG_OLIM = 3'd3,
    CFG_ILIM = 3'd4
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== design/pidpi_in_stage.sv =====
// Input register stage: captures one input word and holds it until the core takes it.
// Depends on pidpi_pkg.
`default_nettype none

module pidpi_in_stage import pidpi_pkg::*; #(
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [FUNC_W-1:0]                func_i,
  input  wire logic signed [DATA_WIDTH-1:0]     setpoint_i,
  input  wire logic signed [DATA_WIDTH-1:0]     feedback_i,
  input  wire logic signed [DATA_WIDTH:0]       term_error_i,
  input  wire logic signed [INTEGRAL_WIDTH-1:0] term_integral_i,
  input  wire logic signed [DATA_WIDTH:0]       term_derivative_i,
  input  wire logic                             adv_i,
  output      logic                             valid_o,
  output      func_e                            func_o,
  output      logic signed [DATA_WIDTH-1:0]     setpoint_o,
  output      logic signed [DATA_WIDTH-1:0]     feedback_o,
  output      logic signed [DATA_WIDTH:0]       term_error_o,
  output      logic signed [INTEGRAL_WIDTH-1:0] term_integral_o,
  output      logic signed [DATA_WIDTH:0]       term_derivative_o
);

  logic valid_q, valid_d;
  logic load;

  assign in_stall_o = valid_q & ~adv_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~adv_i);
  assign valid_o    = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      func_o            <= func_e'(func_i);
      setpoint_o        <= setpoint_i;
      feedback_o        <= feedback_i;
      term_error_o      <= term_error_i;
      term_integral_o   <= term_integral_i;
      term_derivative_o <= term_derivative_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/pidpi_core.sv =====
// Controller state and the single-pass PID arithmetic: error, integral clamp,
// three gain products, floor shift, output clamp and incremental saturation. Uses pidpi_pkg.
`default_nettype none

module pidpi_core import pidpi_pkg::*; #(
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             fire_i,
  input  wire func_e                            func_i,
  input  wire logic signed [DATA_WIDTH-1:0]     setpoint_i,
  input  wire logic signed [DATA_WIDTH-1:0]     feedback_i,
  input  wire logic signed [DATA_WIDTH:0]       term_error_i,
  input  wire logic signed [INTEGRAL_WIDTH-1:0] term_integral_i,
  input  wire logic signed [DATA_WIDTH:0]       term_derivative_i,
  input  wire logic signed [GAIN_W-1:0]         kp_i,
  input  wire logic signed [GAIN_W-1:0]         ki_i,
  input  wire logic signed [GAIN_W-1:0]         kd_i,
  input  wire logic [DATA_WIDTH-2:0]            olim_i,
  input  wire logic [INTEGRAL_WIDTH-2:0]        ilim_i,
  output      logic signed [DATA_WIDTH-1:0]     result_o
);

  localparam int DW  = DATA_WIDTH;
  localparam int IW  = INTEGRAL_WIDTH;
  localparam int EW  = DW + 1;
  localparam int DFW = DW + 2;
  localparam int DDW = DW + 3;
  localparam int AW  = ((IW > EW) ? IW : EW) + 1;
  localparam int MW  = (IW > DDW) ? IW : DDW;
  localparam int PW  = GAIN_W + MW;
  localparam int SW  = PW + 2;

  localparam logic signed [DW:0] OMax = $signed({2'b00, {(DW-1){1'b1}}});
  localparam logic signed [DW:0] OMin = $signed({2'b11, {(DW-1){1'b0}}});

  logic signed [IW-1:0] iacc_q, iacc_d;
  logic signed [EW-1:0] last_q, last_d;
  logic signed [EW-1:0] bl_q, bl_d;
  logic signed [DW-1:0] held_q, held_d;

  logic signed [EW-1:0]  err;
  logic signed [DFW-1:0] d1;
  logic signed [DDW-1:0] dd;
  logic signed [AW-1:0]  ipre, iclamp, ilim_s;
  logic signed [IW-1:0]  inew;
  logic signed [MW-1:0]  opp, opi, opd;
  logic signed [PW-1:0]  pp, pi, pd;
  logic signed [SW-1:0]  sum, shr, oclamp, olim_s;
  logic signed [DW-1:0]  clamped;
  logic signed [DW:0]    isum, isat;
  logic signed [DW-1:0]  res;

  assign err = EW'(setpoint_i) - EW'(feedback_i);
  assign d1  = DFW'(err) - DFW'(last_q);
  assign dd  = DDW'(err) - (DDW'(last_q) <<< 1) + DDW'(bl_q);

  assign ilim_s = AW'($signed({1'b0, ilim_i}));
  assign ipre   = AW'(iacc_q) + AW'(err);

  always_comb begin
    if (ipre > ilim_s) begin
      iclamp = ilim_s;
    end else if (ipre < -ilim_s) begin
      iclamp = -ilim_s;
    end else begin
      iclamp = ipre;
    end
  end

  assign inew = iclamp[IW-1:0];

  always_comb begin
    unique case (func_i)
      FUNC_POS: begin
        opp = MW'(err);
        opi = MW'(inew);
        opd = MW'(d1);
      end
      FUNC_DIRECT: begin
        opp = MW'(term_error_i);
        opi = MW'(term_integral_i);
        opd = MW'(term_derivative_i);
      end
      FUNC_INCR: begin
        opp = MW'(d1);
        opi = MW'(err);
        opd = MW'(dd);
      end
      FUNC_CLEAR: begin
        opp = '0;
        opi = '0;
        opd = '0;
      end
    endcase
  end

  assign pp  = PW'(kp_i) * PW'(opp);
  assign pi  = PW'(ki_i) * PW'(opi);
  assign pd  = PW'(kd_i) * PW'(opd);
  assign sum = SW'(pp) + SW'(pi) + SW'(pd);
  assign shr = sum >>> GAIN_FRAC_BITS;

  assign olim_s = SW'($signed({1'b0, olim_i}));

  always_comb begin
    if (shr > olim_s) begin
      oclamp = olim_s;
    end else if (shr < -olim_s) begin
      oclamp = -olim_s;
    end else begin
      oclamp = shr;
    end
  end

  assign clamped = oclamp[DW-1:0];
  assign isum    = (DW+1)'(held_q) + (DW+1)'(clamped);

  always_comb begin
    if (isum > OMax) begin
      isat = OMax;
    end else if (isum < OMin) begin
      isat = OMin;
    end else begin
      isat = isum;
    end
  end

  always_comb begin
    iacc_d = iacc_q;
    last_d = last_q;
    bl_d   = bl_q;
    unique case (func_i)
      FUNC_POS: begin
        res    = clamped;
        iacc_d = inew;
        last_d = err;
      end
      FUNC_DIRECT: begin
        res    = clamped;
        iacc_d = term_integral_i;
      end
      FUNC_INCR: begin
        res    = isat[DW-1:0];
        bl_d   = last_q;
        last_d = err;
      end
      FUNC_CLEAR: begin
        res    = '0;
        iacc_d = '0;
        last_d = '0;
      end
    endcase
    held_d = res;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iacc_q <= '0;
      last_q <= '0;
      bl_q   <= '0;
      held_q <= '0;
    end else if (fire_i) begin
      iacc_q <= iacc_d;
      last_q <= last_d;
      bl_q   <= bl_d;
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/pidpi_out_stage.sv =====
// Result register: holds one output word until the consumer takes it.
// Depends on pidpi_pkg.
`default_nettype none

module pidpi_out_stage import pidpi_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire logic signed [DATA_WIDTH-1:0] result_i,
  output      logic                         take_o,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic signed [DATA_WIDTH-1:0] control_out_o
);

  logic valid_q, valid_d;
  logic signed [DATA_WIDTH-1:0] data_q;

  assign take_o      = ~valid_q | ~out_stall_i;
  assign valid_d     = load_i | (valid_q & out_stall_i);
  assign out_valid_o = valid_q;
  assign control_out_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/pid_controller_pos_incr.sv =====
// Top level of the fixed-point PID controller: configuration registers, input
// stage, core and result stage. Depends on pidpi_pkg and the pidpi_* modules.
//
//   channel | direction | handshake                   | word
//   --------+-----------+-----------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o     | func, setpoint, feedback, terms
//   out     | output    | out_valid_o / out_stall_i   | control_out
//   cfg     | input     | cfg_we_i (no handshake)     | cfg_idx_i, cfg_wdata_i
//
// Words pass the input register, the core and the result register in turn.
// One word per cycle while out_stall_i is low, set by the controller state loop.
// Reset clears gains, limits, integral, error history and held output.
// An output stall backs up through the result and input registers to in_stall_o.
`default_nettype none

module pid_controller_pos_incr import pidpi_pkg::*; #(
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  localparam int CfgMax1 = (GAIN_W > DATA_WIDTH - 1) ? GAIN_W : DATA_WIDTH - 1,
  localparam int CfgW = (CfgMax1 > INTEGRAL_WIDTH - 1) ? CfgMax1 : INTEGRAL_WIDTH - 1
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]             cfg_idx_i,
  input  wire logic [CfgW-1:0]                  cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [FUNC_W-1:0]                func_i,
  input  wire logic signed [DATA_WIDTH-1:0]     setpoint_i,
  input  wire logic signed [DATA_WIDTH-1:0]     feedback_i,
  input  wire logic signed [DATA_WIDTH:0]       term_error_i,
  input  wire logic signed [INTEGRAL_WIDTH-1:0] term_integral_i,
  input  wire logic signed [DATA_WIDTH:0]       term_derivative_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic signed [DATA_WIDTH-1:0]     control_out_o
);

  logic signed [GAIN_W-1:0]    kp_q, ki_q, kd_q;
  logic [DATA_WIDTH-2:0]       olim_q;
  logic [INTEGRAL_WIDTH-2:0]   ilim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
      olim_q <= '0;
      ilim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KP:   kp_q   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_KI:   ki_q   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_KD:   kd_q   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_OLIM: olim_q <= cfg_wdata_i[DATA_WIDTH-2:0];
        CFG_ILIM: ilim_q <= cfg_wdata_i[INTEGRAL_WIDTH-2:0];
        default: begin
        end
      endcase
    end
  end

  logic                             s1_valid;
  logic                             fire;
  logic                             take;
  func_e                            s1_func;
  logic signed [DATA_WIDTH-1:0]     s1_sp, s1_fb;
  logic signed [DATA_WIDTH:0]       s1_te, s1_td;
  logic signed [INTEGRAL_WIDTH-1:0] s1_ti;
  logic signed [DATA_WIDTH-1:0]     result;

  assign fire = s1_valid & take;

  pidpi_in_stage #(
    .DATA_WIDTH    (DATA_WIDTH),
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
  ) u_in (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .setpoint_i       (setpoint_i),
    .feedback_i       (feedback_i),
    .term_error_i     (term_error_i),
    .term_integral_i  (term_integral_i),
    .term_derivative_i(term_derivative_i),
    .adv_i            (take),
    .valid_o          (s1_valid),
    .func_o           (s1_func),
    .setpoint_o       (s1_sp),
    .feedback_o       (s1_fb),
    .term_error_o     (s1_te),
    .term_integral_o  (s1_ti),
    .term_derivative_o(s1_td)
  );

  pidpi_core #(
    .DATA_WIDTH    (DATA_WIDTH),
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .func_i           (s1_func),
    .setpoint_i       (s1_sp),
    .feedback_i       (s1_fb),
    .term_error_i     (s1_te),
    .term_integral_i  (s1_ti),
    .term_derivative_i(s1_td),
    .kp_i             (kp_q),
    .ki_i             (ki_q),
    .kd_i             (kd_q),
    .olim_i           (olim_q),
    .ilim_i           (ilim_q),
    .result_o         (result)
  );

  pidpi_out_stage #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (fire),
    .result_i     (result),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .control_out_o(control_out_o)
  );

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (s1_func == FUNC_CLEAR) |=> out_valid_o && (control_out_o == '0))
    else $error("clear did not give a zero output word");

  a_out_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (s1_func != FUNC_INCR) |=>
      ($signed(control_out_o) <= $signed({1'b0, olim_q})) &&
      ($signed(control_out_o) >= -$signed({1'b0, olim_q})))
    else $error("output word outside the output limit");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid && out_valid_o && out_stall_i)
    else $error("input stalled without a held word");

endmodule

`default_nettype wire
